// ===== sv/dbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dbs_pkg: shared types, codes and helpers for the deque/bag store
// Sizes of the store, request and response payloads, request and status
// codes, and slot arithmetic for the circular buffer.
// ----------------------------------------------------------------------------
package dbs_pkg;

   localparam int DEPTH      = 16;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   // request codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_CONTAINS   = 3'd4;
   localparam logic [2:0] OP_REMOVE     = 3'd5;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [VALUE_BITS-1:0] val_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] value;
   } req_pld_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic               is_empty;
      logic [4:0]         entry_total;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_pld_type;

   // physical slot of logical position pos, counted from the head
   function automatic addr_type slot_of(input addr_type head, input addr_type pos);
      logic [ADDR_BITS:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (ADDR_BITS + 1)'(DEPTH)) begin
         sum = sum - (ADDR_BITS + 1)'(DEPTH);
      end
      return sum[ADDR_BITS-1:0];
   endfunction

   // sign-extend the request value to the stored width
   function automatic val_type widen(input logic signed [31:0] value);
      logic signed [63:0] ext;
      ext = 64'(value);
      return ext[VALUE_BITS-1:0];
   endfunction

   // low 32 bits of a stored value, zero-extended when narrower
   function automatic logic [31:0] narrow(input val_type v);
      logic [63:0] ext;
      ext = 64'(v);
      return ext[31:0];
   endfunction

endpackage

// ===== sv/dbs_ram.sv =====
// ----------------------------------------------------------------------------
// dbs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module dbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbs_ctrl: request sequencer for the deque/bag store
// Keeps head and occupancy, drives the slot RAM for pushes, the pipelined
// search, the gap-closing shift and the front/back reads, and builds the
// response for each request.
// ----------------------------------------------------------------------------
module dbs_ctrl import dbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_pld_type req_data,
   output logic        wr_en,
   output addr_type    wr_addr,
   output val_type     wr_data,
   output logic        rd_en,
   output addr_type    rd_addr,
   input  val_type     rd_data,
   output logic        res_load,
   output rsp_pld_type res_data,
   input  logic        res_busy
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_RDF   = 3'd3;
   localparam logic [2:0] S_RDB   = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;
   addr_type   head_ff, head_in;
   cnt_type    occ_ff, occ_in;
   logic [2:0] op_ff, op_in;
   val_type    val_ff, val_in;
   logic [1:0] status_ff, status_in;
   logic       found_ff, found_in;
   cnt_type    pos_ff, pos_in;
   addr_type   cmp_pos_ff, cmp_pos_in;
   logic       rd_vld_ff, rd_vld_in;
   addr_type   wr_pos_ff, wr_pos_in;
   logic       wr_vld_ff, wr_vld_in;
   val_type    front_ff, front_in;

   logic       full;
   logic       empty;
   cnt_type    occ_dec;
   addr_type   occ_m1;
   cnt_type    pos_dec;
   addr_type   head_dec;
   addr_type   head_inc;
   val_type    new_val;
   logic       hit;
   logic       last;

   assign full     = (occ_ff == CNT_BITS'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign occ_dec  = occ_ff - CNT_BITS'(1);
   assign occ_m1   = occ_dec[ADDR_BITS-1:0];
   assign pos_dec  = pos_ff - CNT_BITS'(1);
   assign head_dec = (head_ff == '0) ? ADDR_BITS'(DEPTH - 1) : head_ff - ADDR_BITS'(1);
   assign head_inc = (head_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : head_ff + ADDR_BITS'(1);
   assign new_val  = widen(req_data.value);
   assign hit      = rd_vld_ff && (rd_data == val_ff);
   assign last     = rd_vld_ff && (cmp_pos_ff == occ_m1);
   assign req_ready = (state_ff == S_IDLE);

   // sequence one request
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      occ_in     = occ_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      cmp_pos_in = cmp_pos_ff;
      rd_vld_in  = rd_vld_ff;
      wr_pos_in  = wr_pos_ff;
      wr_vld_in  = wr_vld_ff;
      front_in   = front_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      res_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.req_type;
               val_in    = new_val;
               status_in = STAT_OK;
               found_in  = 1'b0;
               state_in  = S_RDF;
               unique case (req_data.req_type)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        wr_data = new_val;
                        head_in = head_dec;
                        occ_in  = occ_ff + CNT_BITS'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_of(head_ff, occ_ff[ADDR_BITS-1:0]);
                        wr_data = new_val;
                        occ_in  = occ_ff + CNT_BITS'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        head_in = head_inc;
                        occ_in  = occ_dec;
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        occ_in = occ_dec;
                     end
                  end
                  OP_CONTAINS: begin
                     if (!empty) begin
                        state_in  = S_SCAN;
                        pos_in    = '0;
                        rd_vld_in = 1'b0;
                     end
                  end
                  OP_REMOVE: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in  = S_SCAN;
                        pos_in    = '0;
                        rd_vld_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // issue one read a cycle, compare the entry read the cycle before
         S_SCAN: begin
            if (hit) begin
               found_in  = 1'b1;
               rd_vld_in = 1'b0;
               if (op_ff == OP_REMOVE) begin
                  state_in  = S_SHIFT;
                  pos_in    = CNT_BITS'(cmp_pos_ff) + CNT_BITS'(1);
                  wr_vld_in = 1'b0;
               end else begin
                  state_in = S_RDF;
               end
            end else if (last) begin
               rd_vld_in = 1'b0;
               state_in  = S_RDF;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = slot_of(head_ff, pos_ff[ADDR_BITS-1:0]);
               cmp_pos_in = pos_ff[ADDR_BITS-1:0];
               rd_vld_in  = 1'b1;
               pos_in     = pos_ff + CNT_BITS'(1);
            end
         end

         // move each later entry up by one: read next, write it one slot ahead
         S_SHIFT: begin
            if (wr_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = slot_of(head_ff, wr_pos_ff);
               wr_data = rd_data;
            end
            if (pos_ff < occ_ff) begin
               rd_en     = 1'b1;
               rd_addr   = slot_of(head_ff, pos_ff[ADDR_BITS-1:0]);
               wr_pos_in = pos_dec[ADDR_BITS-1:0];
               wr_vld_in = 1'b1;
               pos_in    = pos_ff + CNT_BITS'(1);
            end else begin
               wr_vld_in = 1'b0;
               occ_in    = occ_dec;
               state_in  = S_RDF;
            end
         end

         // read the front entry
         S_RDF: begin
            if (empty) begin
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = S_RDB;
            end
         end

         // capture front, read the back entry
         S_RDB: begin
            front_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, occ_m1);
            state_in = S_RESP;
         end

         // hand the response over once the output register is free
         S_RESP: begin
            if (!res_busy) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response fields; back value sits in the RAM read register
   always_comb begin
      res_data.status      = status_ff;
      res_data.found       = found_ff;
      res_data.is_empty    = empty;
      res_data.entry_total = 5'(occ_ff);
      res_data.front_value = empty ? '0 : narrow(front_ff);
      res_data.back_value  = empty ? '0 : narrow(rd_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         occ_ff    <= '0;
         rd_vld_ff <= 1'b0;
         wr_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         occ_ff    <= occ_in;
         rd_vld_ff <= rd_vld_in;
         wr_vld_ff <= wr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      cmp_pos_ff <= cmp_pos_in;
      wr_pos_ff  <= wr_pos_in;
      front_ff   <= front_in;
   end

endmodule

// ===== sv/deque_bag_store.sv =====
// ----------------------------------------------------------------------------
// deque_bag_store: bounded double-ended queue that also works as a bag
// Requests enter on req_valid/req_ready with a request code and a value;
// each request returns exactly one response on rsp_valid/rsp_ready giving
// status, found flag, emptiness, entry count and front and back values.
// Requests are handled one at a time by a sequencer around one slot RAM
// with a registered read.
// Steps from acceptance to response valid:
//   push, pop, refused requests and spare codes: front read, back read,
//   then the response load (both reads skipped when the store ends empty).
//   contains: no search on an empty store, otherwise a search with
//   one RAM read per entry searched, then the front and back reads.
//   remove: the same search, which stops at the match; the gap closing
//   then reads and writes each later entry once.
// Requests are not overlapped: the next request is accepted in the cycle
// after a response is loaded, even while that response still waits.
// Reset empties the store at once; slot contents are left as they were.
// When the receiver stalls, the response holds in the output register and
// at most one further request is processed before the block stops taking
// requests.
// ----------------------------------------------------------------------------
module deque_bag_store import dbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_pld_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_pld_type rsp_data
);

   logic        wr_en;
   addr_type    wr_addr;
   val_type     wr_data;
   logic        rd_en;
   addr_type    rd_addr;
   val_type     rd_data;
   logic        res_load;
   rsp_pld_type res_data;
   logic        res_busy;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_pld_type rsp_data_ff;

   dbs_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_load  (res_load),
      .res_data  (res_data),
      .res_busy  (res_busy)
   );

   // hold the response until taken
   assign res_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/dbs_checker.sv =====
// ----------------------------------------------------------------------------
// dbs_checker: port-level checks for the deque/bag store
// Watches the response channel for stall behavior and for consistency of
// the reported store state; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module dbs_checker import dbs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rsp_pld_type rsp_data
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // empty flag agrees with count, and count stays within capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_total == 5'd0))
                    && (rsp_data.entry_total <= 5'(DEPTH)))
      else $error("entry count and empty flag disagree");

   // an empty store reports zero front and back values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.front_value == '0 && rsp_data.back_value == '0)
      else $error("empty store shows nonzero end values");

   // a refused request never reports a match and carries a full or empty status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |->
         !rsp_data.found && (rsp_data.status == STAT_FULL || rsp_data.status == STAT_EMPTY))
      else $error("bad status or found on refused request");

   // no request is taken in the cycle after one is accepted
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

endmodule

bind deque_bag_store dbs_checker u_dbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
